### rtl/core/sql_text_tokenizer_defines.svh
// Assertion macros shared by the tokenizer checkers.
`ifndef SQL_TEXT_TOKENIZER_DEFINES_SVH
`define SQL_TEXT_TOKENIZER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define SQLTOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the following edge.
`define SQLTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sqltok_pkg.sv
// Shared types, codes and character helpers for the SQL text tokenizer.
package sqltok_pkg;

  localparam int POS_BITS    = 16;
  localparam int EXT_W       = (POS_BITS > 16) ? POS_BITS : 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Scan modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_WORD   = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_OPER   = 3'd4;

  // Pending operator codes.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_GT   = 2'd1;
  localparam logic [1:0] PEND_LT   = 2'd2;
  localparam logic [1:0] PEND_BANG = 2'd3;

  // Token kinds.
  localparam logic [4:0] KIND_EOF    = 5'd0;
  localparam logic [4:0] KIND_WORD   = 5'd1;
  localparam logic [4:0] KIND_NUMBER = 5'd2;
  localparam logic [4:0] KIND_STRING = 5'd3;
  localparam logic [4:0] KIND_STRAY  = 5'd4;
  localparam logic [4:0] KIND_GT     = 5'd5;
  localparam logic [4:0] KIND_GE     = 5'd6;
  localparam logic [4:0] KIND_LT     = 5'd7;
  localparam logic [4:0] KIND_LE     = 5'd8;
  localparam logic [4:0] KIND_NE_LG  = 5'd9;
  localparam logic [4:0] KIND_NE     = 5'd10;
  localparam logic [4:0] KIND_EQ     = 5'd11;
  localparam logic [4:0] KIND_DOT    = 5'd12;
  localparam logic [4:0] KIND_PLUS   = 5'd13;
  localparam logic [4:0] KIND_MINUS  = 5'd14;
  localparam logic [4:0] KIND_STAR   = 5'd15;
  localparam logic [4:0] KIND_SLASH  = 5'd16;
  localparam logic [4:0] KIND_CARET  = 5'd17;
  localparam logic [4:0] KIND_PCT    = 5'd18;
  localparam logic [4:0] KIND_BANG   = 5'd19;
  localparam logic [4:0] KIND_QMARK  = 5'd20;
  localparam logic [4:0] KIND_LPAREN = 5'd21;
  localparam logic [4:0] KIND_RPAREN = 5'd22;
  localparam logic [4:0] KIND_COMMA  = 5'd23;
  localparam logic [4:0] KIND_SEMI   = 5'd24;

  // Characters.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  typedef struct packed {
    tok_t       first;
    tok_t       second;
    logic [1:0] count;
  } emit_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return c == CH_SQUOTE || c == CH_DQUOTE;
  endfunction

  // Single punctuation kind, KIND_EOF when the byte is none of them.
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h3D:   k = KIND_EQ;
      8'h2E:   k = KIND_DOT;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h5E:   k = KIND_CARET;
      8'h25:   k = KIND_PCT;
      8'h3F:   k = KIND_QMARK;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h2C:   k = KIND_COMMA;
      8'h3B:   k = KIND_SEMI;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_BITS'(1);
  endfunction

  function automatic logic [POS_BITS-1:0] span(input logic [POS_BITS-1:0] from,
                                               input logic [POS_BITS-1:0] to);
    return (to > from) ? to - from : '0;
  endfunction

  // Report a position-wide value on the 16-bit fields, saturating.
  function automatic logic [15:0] clamp16(input logic [POS_BITS-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'(v);
    return (w > EXT_W'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

### rtl/core/sqltok_lexer.sv
// Scan state and per-byte token decision logic.
module sqltok_lexer
  import sqltok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] text_byte,
  output emit_t      emit
);

  logic [2:0]          mode_r, mode_nxt;
  logic [1:0]          pend_r, pend_nxt;
  logic [POS_BITS-1:0] begin_r, begin_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;

  logic                consumed;
  logic                e0_v, e1_v;
  logic [4:0]          e0_kind, e1_kind;
  logic [POS_BITS-1:0] e0_len, e1_len;
  logic [4:0]          pair_kind, single_kind;
  tok_t                tok0, tok1;

  always_comb begin
    mode_nxt    = mode_r;
    pend_nxt    = pend_r;
    begin_nxt   = begin_r;
    consumed    = 1'b0;
    e0_v        = 1'b0;
    e0_kind     = KIND_EOF;
    e0_len      = '0;
    e1_v        = 1'b0;
    e1_kind     = KIND_EOF;
    e1_len      = '0;
    pair_kind   = KIND_EOF;
    single_kind = KIND_BANG;

    // Close or extend the open token.
    case (mode_r)
      MODE_WORD: begin
        if (is_alpha(text_byte) || is_digit(text_byte)) begin
          consumed = 1'b1;
        end else begin
          e0_v     = 1'b1;
          e0_kind  = KIND_WORD;
          e0_len   = span(begin_r, pos_r);
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(text_byte) || text_byte == CH_DOT) begin
          consumed = 1'b1;
        end else begin
          e0_v     = 1'b1;
          e0_kind  = KIND_NUMBER;
          e0_len   = span(begin_r, pos_r);
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (is_quote(text_byte) || text_byte == CH_NUL) begin
          e0_v     = 1'b1;
          e0_kind  = KIND_STRING;
          e0_len   = span(begin_r, pos_r);
          mode_nxt = MODE_IDLE;
          consumed = (text_byte != CH_NUL);
        end else begin
          consumed = 1'b1;
        end
      end
      MODE_OPER: begin
        case (pend_r)
          PEND_GT: begin
            single_kind = KIND_GT;
            if (text_byte == CH_EQ) pair_kind = KIND_GE;
          end
          PEND_LT: begin
            single_kind = KIND_LT;
            if (text_byte == CH_EQ) pair_kind = KIND_LE;
            else if (text_byte == CH_GT) pair_kind = KIND_NE_LG;
          end
          default: begin
            single_kind = KIND_BANG;
            if (text_byte == CH_EQ) pair_kind = KIND_NE;
          end
        endcase
        e0_v = 1'b1;
        if (pair_kind != KIND_EOF) begin
          e0_kind  = pair_kind;
          e0_len   = POS_BITS'(2);
          consumed = 1'b1;
        end else begin
          e0_kind = single_kind;
          e0_len  = POS_BITS'(1);
        end
        mode_nxt = MODE_IDLE;
        pend_nxt = PEND_NONE;
      end
      default: mode_nxt = MODE_IDLE;
    endcase

    // Handle the byte as a fresh start.
    if (!consumed) begin
      if (text_byte == CH_NUL) begin
        e1_v    = 1'b1;
        e1_kind = KIND_EOF;
      end else if (is_blank(text_byte)) begin
        e1_v = 1'b0;
      end else if (is_alpha(text_byte)) begin
        mode_nxt  = MODE_WORD;
        begin_nxt = pos_r;
      end else if (is_digit(text_byte)) begin
        mode_nxt  = MODE_NUMBER;
        begin_nxt = pos_r;
      end else if (is_quote(text_byte)) begin
        mode_nxt  = MODE_STRING;
        begin_nxt = sat_inc(pos_r);
      end else if (text_byte == CH_GT || text_byte == CH_LT || text_byte == CH_BANG) begin
        mode_nxt  = MODE_OPER;
        begin_nxt = pos_r;
        if (text_byte == CH_GT) pend_nxt = PEND_GT;
        else if (text_byte == CH_LT) pend_nxt = PEND_LT;
        else pend_nxt = PEND_BANG;
      end else if (punct_kind(text_byte) != KIND_EOF) begin
        e1_v    = 1'b1;
        e1_kind = punct_kind(text_byte);
        e1_len  = POS_BITS'(1);
      end else begin
        e1_v    = 1'b1;
        e1_kind = KIND_STRAY;
      end
    end

    // End of text rewinds everything.
    if (text_byte == CH_NUL) begin
      mode_nxt  = MODE_IDLE;
      pend_nxt  = PEND_NONE;
      begin_nxt = '0;
      pos_nxt   = '0;
    end else begin
      pos_nxt = sat_inc(pos_r);
    end
  end

  always_comb begin
    tok0.kind   = e0_kind;
    tok0.start  = clamp16(begin_r);
    tok0.length = clamp16(e0_len);
    tok0.last   = !e1_v;
    tok1.kind   = e1_kind;
    tok1.start  = clamp16(pos_r);
    tok1.length = clamp16(e1_len);
    tok1.last   = 1'b1;
    emit.first  = e0_v ? tok0 : tok1;
    emit.second = tok1;
    emit.count  = step_en ? (2'(e0_v) + 2'(e1_v)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pend_r  <= PEND_NONE;
      begin_r <= '0;
      pos_r   <= '0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

### rtl/core/sqltok_out_queue.sv
// Small token queue that takes up to two tokens a cycle and sends one while out_stall is low.
module sqltok_out_queue
  import sqltok_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  emit_t emit,
  output logic  full,
  output logic  out_valid,
  input  logic  out_stall,
  output tok_t  head
);

  tok_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign full      = (count_r > QCNT_W'(QUEUE_DEPTH - 2));
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(emit.count);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(emit.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (emit.count != 2'd0) begin
      mem_r[wr_ptr_r] <= emit.first;
    end
    if (emit.count == 2'd2) begin
      mem_r[wr_ptr_r + QPTR_W'(1)] <= emit.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/core/sql_text_tokenizer.sv
// Streaming SQL tokenizer: one text byte in per request, tokens out.
//
// Input channel: in_valid / in_stall carry one text byte per request in
// in_text_byte. Byte 0 ends the text: any open token is closed, an eof
// token follows at the byte's position, and the position rewinds to 0.
// Output channel: out_valid / out_stall carry one token per request:
// kind, start position, length and a flag marking the final token that
// its byte produced. A byte yields zero, one or two tokens.
// Each token is written into the output queue when its byte is taken.
// Bytes are taken one per cycle while in_stall is low; the output sends
// one token per cycle while out_stall is low, from a four-entry queue;
// in_stall rises while it holds three or more, so a byte always finds room for two.
// Reset (synchronous, rst_n low) empties the queue and returns the
// scanner to idle at position 0.
// When the receiver stalls, the head token holds on the output until it
// is taken; bytes keep flowing until the queue fills.
module sql_text_tokenizer
  import sqltok_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  emit_t emit;
  tok_t  head;
  logic  queue_full;
  logic  step_en;

  // Take a byte only when the queue has room for two tokens.
  assign in_stall = queue_full;
  assign step_en  = in_valid && !queue_full;

  // Advance the scan state and decide the tokens of this byte.
  sqltok_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .text_byte (in_text_byte),
    .emit      (emit)
  );

  // Hold tokens until the receiver takes them.
  sqltok_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_last_of_run  = head.last;

endmodule

### rtl/core/sqltok_checker.sv
// Port-level checks for the SQL tokenizer and their binding.
`include "sql_text_tokenizer_defines.svh"

module sqltok_checker
  import sqltok_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_text_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_token_kind,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_length,
  input logic        out_last_of_run
);

  `SQLTOK_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_token_kind) && $stable(out_token_start)
      && $stable(out_token_length) && $stable(out_last_of_run),
    "stalled token changed")

  `SQLTOK_ASSERT(a_kind_range, !out_valid || out_token_kind <= KIND_SEMI,
    "token kind out of range")

  `SQLTOK_ASSERT(a_zero_len,
    !out_valid || !(out_token_kind == KIND_EOF || out_token_kind == KIND_STRAY)
      || out_token_length == 16'd0,
    "eof or stray token with nonzero length")

  `SQLTOK_ASSERT(a_pair_len,
    !out_valid || !(out_token_kind == KIND_GE || out_token_kind == KIND_LE
      || out_token_kind == KIND_NE_LG || out_token_kind == KIND_NE)
      || out_token_length == 16'd2,
    "two-byte comparison without length two")

  `SQLTOK_ASSERT(a_eof_last, !out_valid || out_token_kind != KIND_EOF || out_last_of_run,
    "eof token not last of its byte")

endmodule

bind sql_text_tokenizer sqltok_checker u_sqltok_checker (.*);
